FILE: rtl/core/asxp_pkg.sv
// Shared types and constants for the sentence parser blocks.
`timescale 1ns / 1ps

package asxp_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_F      = 8'h46;
    localparam logic [7:0] CHAR_L      = 8'h4C;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;

    localparam int MIN_LINE_LEN = 8;
    localparam int HDR_LAST_POS = 3;
    localparam logic [7:0] CHECK_BAD  = 8'hFF;
    localparam logic [3:0] NIBBLE_BAD = 4'hF;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEVEL  = 3'd1,
        PH_RATE   = 3'd2,
        PH_CHECK  = 3'd3,
        PH_DEAD   = 3'd4
    } t_phase;

    // One received byte together with its character class.
    typedef struct packed {
        logic [7:0] data;
        logic       is_lf;
        logic       is_cr;
        logic       is_comma;
        logic       is_nul;
        logic       is_digit;
        logic [3:0] digit;
        logic       hex_ok;
        logic [3:0] nibble;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: rtl/core/asxp_front.sv
// Front end: accepts received bytes and tags each with its character class.
`timescale 1ns / 1ps

module asxp_front
    import asxp_pkg::*;
(
    input  logic          i_valid,
    input  logic [7:0]    i_data,
    input  t_queue_status i_status,
    output logic          o_ready,
    output logic          o_push,
    output t_item         o_item
);

    logic is_dec;
    logic is_upper;
    logic is_lower;

    always_comb begin
        is_dec   = (i_data >= CHAR_ZERO) && (i_data <= CHAR_NINE);
        is_upper = (i_data >= CHAR_UA) && (i_data <= CHAR_UF);
        is_lower = (i_data >= CHAR_LA) && (i_data <= CHAR_LF_HEX);

        o_item.data     = i_data;
        o_item.is_lf    = (i_data == CHAR_LF);
        o_item.is_cr    = (i_data == CHAR_CR);
        o_item.is_comma = (i_data == CHAR_COMMA);
        o_item.is_nul   = (i_data == 8'h00);
        o_item.is_digit = is_dec;
        o_item.digit    = 4'(i_data - CHAR_ZERO);
        o_item.hex_ok   = is_dec || is_upper || is_lower;
        if (is_dec) begin
            o_item.nibble = 4'(i_data - CHAR_ZERO);
        end else if (is_upper) begin
            o_item.nibble = 4'(i_data - CHAR_UA + 8'd10);
        end else if (is_lower) begin
            o_item.nibble = 4'(i_data - CHAR_LA + 8'd10);
        end else begin
            o_item.nibble = NIBBLE_BAD;
        end
    end

    assign o_ready = !i_status.full;
    assign o_push  = i_valid && !i_status.full;

endmodule

FILE: rtl/core/asxp_queue.sv
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps

module asxp_queue
    import asxp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/core/asxp_back.sv
// Back end: per-line parser state, checksum test and result register.
`timescale 1ns / 1ps

module asxp_back
    import asxp_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_item         i_item,
    input  t_queue_status i_status,
    input  logic [7:0]    i_max_level,
    input  logic          i_out_ready,
    output logic          o_pop,
    output logic          o_out_valid,
    output logic [7:0]    o_level,
    output logic [15:0]   o_rate
);

    localparam int POS_W = $clog2(LINE_MAX);

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_hdr_ok, n_hdr_ok;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_lvl, n_lvl;
    logic             r_lvl_stop, n_lvl_stop;
    logic [15:0]      r_rate, n_rate;
    logic             r_rate_stop, n_rate_stop;
    logic [7:0]       r_chk, n_chk;
    logic [1:0]       r_hex_cnt, n_hex_cnt;
    logic             r_out_valid;
    logic [7:0]       r_out_level;
    logic [15:0]      r_out_rate;

    logic             parse_en;
    logic [7:0]       recv_chk;
    logic [7:0]       calc_chk;
    logic             line_good;

    // Take a byte whenever the result register can absorb a possible result.
    assign o_pop    = !i_status.empty && (!r_out_valid || i_out_ready);
    assign parse_en = o_pop && !i_item.is_lf && !i_item.is_cr &&
                      (r_pos < POS_W'(LINE_MAX - 1));

    assign recv_chk  = (r_hex_cnt < 2'd2) ? CHECK_BAD : r_chk;
    assign calc_chk  = r_xor ^ CHAR_F ^ CHAR_L;
    assign line_good = (r_pos >= POS_W'(MIN_LINE_LEN)) && r_hdr_ok &&
                       (r_phase == PH_CHECK) && (calc_chk == recv_chk) &&
                       (r_lvl <= i_max_level);

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        if (o_pop && i_item.is_lf) begin
            n_phase = PH_HEADER;
        end else if (parse_en) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos >= POS_W'(HDR_LAST_POS)) n_phase = PH_LEVEL;
                end
                PH_LEVEL: begin
                    if (i_item.is_comma)    n_phase = PH_RATE;
                    else if (i_item.is_nul) n_phase = PH_DEAD;
                end
                PH_RATE: begin
                    if (i_item.is_comma)    n_phase = PH_CHECK;
                    else if (i_item.is_nul) n_phase = PH_DEAD;
                end
                PH_CHECK: n_phase = PH_CHECK;
                PH_DEAD:  n_phase = PH_DEAD;
                default:  n_phase = PH_DEAD;
            endcase
        end
    end

    // Field accumulators.
    always_comb begin
        n_pos       = r_pos;
        n_hdr_ok    = r_hdr_ok;
        n_xor       = r_xor;
        n_lvl       = r_lvl;
        n_lvl_stop  = r_lvl_stop;
        n_rate      = r_rate;
        n_rate_stop = r_rate_stop;
        n_chk       = r_chk;
        n_hex_cnt   = r_hex_cnt;
        if (o_pop && i_item.is_lf) begin
            n_pos       = '0;
            n_hdr_ok    = 1'b0;
            n_xor       = '0;
            n_lvl       = '0;
            n_lvl_stop  = 1'b0;
            n_rate      = '0;
            n_rate_stop = 1'b0;
            n_chk       = '0;
            n_hex_cnt   = '0;
        end else if (parse_en) begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(0)) begin
                        n_hdr_ok = (i_item.data == CHAR_DOLLAR);
                    end else if (r_pos == POS_W'(1)) begin
                        n_hdr_ok = r_hdr_ok && (i_item.data == CHAR_F);
                    end else if (r_pos == POS_W'(2)) begin
                        n_hdr_ok = r_hdr_ok && (i_item.data == CHAR_L);
                    end
                end
                PH_LEVEL: begin
                    if (!i_item.is_comma && !i_item.is_nul) begin
                        n_xor = r_xor ^ i_item.data;
                        if (!r_lvl_stop && i_item.is_digit) begin
                            n_lvl = (r_lvl << 3) + (r_lvl << 1) + {4'd0, i_item.digit};
                        end else begin
                            n_lvl_stop = 1'b1;
                        end
                    end
                end
                PH_RATE: begin
                    if (!i_item.is_comma && !i_item.is_nul) begin
                        n_xor = r_xor ^ i_item.data;
                        if (!r_rate_stop && i_item.is_digit) begin
                            n_rate = (r_rate << 3) + (r_rate << 1) +
                                     {12'd0, i_item.digit};
                        end else begin
                            n_rate_stop = 1'b1;
                        end
                    end
                end
                PH_CHECK: begin
                    if (r_hex_cnt == 2'd0) begin
                        n_chk     = i_item.hex_ok ? {i_item.nibble, 4'h0}
                                                  : {NIBBLE_BAD, 4'h0};
                        n_hex_cnt = 2'd1;
                    end else if (r_hex_cnt == 2'd1) begin
                        n_chk     = i_item.hex_ok ? (r_chk | {4'h0, i_item.nibble})
                                                  : CHECK_BAD;
                        n_hex_cnt = 2'd2;
                    end
                end
                PH_DEAD: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= '0;
            r_hdr_ok    <= 1'b0;
            r_xor       <= '0;
            r_lvl       <= '0;
            r_lvl_stop  <= 1'b0;
            r_rate      <= '0;
            r_rate_stop <= 1'b0;
            r_chk       <= '0;
            r_hex_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_hdr_ok    <= n_hdr_ok;
            r_xor       <= n_xor;
            r_lvl       <= n_lvl;
            r_lvl_stop  <= n_lvl_stop;
            r_rate      <= n_rate;
            r_rate_stop <= n_rate_stop;
            r_chk       <= n_chk;
            r_hex_cnt   <= n_hex_cnt;
            if (o_pop && i_item.is_lf && line_good) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.is_lf && line_good) begin
            r_out_level <= r_lvl;
            r_out_rate  <= r_rate;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_rate      = r_out_rate;

endmodule

FILE: rtl/core/ascii_sentence_xor_checksum_parser.sv
// Top level of the $FL sentence parser with XOR checksum check.
`timescale 1ns / 1ps

// Usage:
// Received characters enter on the s_axis channel, one byte per item in
// s_axis_tdata. Each line feed closes a line; carriage returns are skipped.
// When the closed line is a well-formed $FL sentence whose XOR checksum
// matches and whose level does not exceed max_level, one item leaves on the
// m_axis channel carrying the level and heart rate; otherwise nothing leaves.
// The cfg channel writes max_level (reset value 3); it is always ready.
// Throughput is one byte per cycle while s_axis_tready is high. A byte
// is written into the four-entry queue when it is accepted and is parsed
// by the back end only after it has been stored there; m_axis_tvalid rises
// from the result register once the line feed has been parsed.
// The back end drains the queue one byte per cycle whenever the result
// register is empty or being read; while m_axis is stalled with a result
// pending it holds, the queue fills and s_axis_tready drops when it is full.
// Reset is synchronous and active low: it empties the queue, drops the
// pending result, clears the line state and restores max_level to 3.
// Bytes past the first LINE_MAX-1 of a line are dropped until its line feed.
module ascii_sentence_xor_checksum_parser
    import asxp_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] level, [23:8] heart_rate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    t_item         front_item;
    t_item         queue_item;
    t_queue_status queue_status;
    logic          front_push;
    logic          back_pop;
    logic [7:0]    r_max_level;
    logic [7:0]    out_level;
    logic [15:0]   out_rate;

    // Configuration register; the user must write it only while the parser is idle, the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= 8'd3;
        end else if (cfg_valid) begin
            r_max_level <= cfg_data;
        end
    end

    asxp_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_data   (s_axis_tdata),
        .i_status (queue_status),
        .o_ready  (s_axis_tready),
        .o_push   (front_push),
        .o_item   (front_item)
    );

    asxp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_item   (front_item),
        .i_pop    (back_pop),
        .o_item   (queue_item),
        .o_status (queue_status)
    );

    asxp_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (queue_item),
        .i_status    (queue_status),
        .i_max_level (r_max_level),
        .i_out_ready (m_axis_tready),
        .o_pop       (back_pop),
        .o_out_valid (m_axis_tvalid),
        .o_level     (out_level),
        .o_rate      (out_rate)
    );

    assign m_axis_tdata = {out_rate, out_level};

    // A queue cannot be both full and empty.
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(queue_status.full && queue_status.empty))
        else $error("queue reports full and empty together");

    // A pending, stalled result must block the back end from parsing further.
    a_stall_blocks_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !back_pop)
        else $error("back end consumed a byte while a result was stalled");

    // Reset leaves no result pending.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The front end only pushes when there is room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> (s_axis_tready && !queue_status.full))
        else $error("push into a full queue");

endmodule
